// ===== rtl/core/rav_pkg.sv =====
// Shared constants, types and helpers for the running average window block.
package rav_pkg;

  localparam int MAX_TAPS = 16;
  localparam int DATA_W   = 16;
  localparam int WIN_W    = 5;
  localparam int POS_W    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int SUM_W    = DATA_W + POS_W;
  localparam int EWIN_W   = $clog2(MAX_TAPS + 1);
  localparam int CNT_W    = $clog2(SUM_W + 1);

  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(16);

  typedef struct packed {
    logic                     start;
    logic signed [SUM_W-1:0]  dividend;
    logic [EWIN_W-1:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic [DATA_W-1:0]        quotient;
  } div_rsp_t;

  // Clamp the programmed window into 1..MAX_TAPS.
  function automatic logic [EWIN_W-1:0] eff_window(input logic [WIN_W-1:0] wl);
    logic [EWIN_W-1:0] w;
    if (wl == '0) begin
      w = EWIN_W'(1);
    end else if (int'(wl) > MAX_TAPS) begin
      w = EWIN_W'(MAX_TAPS);
    end else begin
      w = EWIN_W'(wl);
    end
    return w;
  endfunction

endpackage

// ===== rtl/core/rav_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module rav_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/rav_div.sv =====
// Bit-serial signed-by-unsigned divider, truncating toward zero, one bit a cycle.
module rav_div
  import rav_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [CNT_W-1:0]  count;
  logic              neg;
  logic              done;
  logic [SUM_W-1:0]  quo;
  logic [EWIN_W-1:0] rem;
  logic [EWIN_W-1:0] divisor;
  logic [EWIN_W:0]   shifted;
  logic [EWIN_W:0]   trial;
  logic [SUM_W-1:0]  magnitude;
  logic [SUM_W-1:0]  signed_quo;

  assign magnitude = req.dividend[SUM_W-1] ? SUM_W'(-req.dividend) : SUM_W'(req.dividend);
  assign shifted   = {rem, quo[SUM_W-1]};
  assign trial     = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else if (req.start) begin
      count   <= CNT_W'(SUM_W);
      done    <= 1'b0;
      neg     <= req.dividend[SUM_W-1];
      quo     <= magnitude;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (count != '0) begin
      // Restoring step: keep the difference when it does not borrow.
      if (!trial[EWIN_W]) begin
        rem <= trial[EWIN_W-1:0];
        quo <= {quo[SUM_W-2:0], 1'b1};
      end else begin
        rem <= shifted[EWIN_W-1:0];
        quo <= {quo[SUM_W-2:0], 1'b0};
      end
      count <= count - CNT_W'(1);
      if (count == CNT_W'(1)) begin
        done <= 1'b1;
      end
    end
  end

  assign signed_quo   = neg ? (~quo + SUM_W'(1)) : quo;
  assign rsp.done     = done;
  assign rsp.quotient = signed_quo[DATA_W-1:0];

endmodule

// ===== rtl/core/running_average_window.sv =====
// Running average over a sliding window of signed samples, top level.
// From sample acceptance to average valid: read, update, one divide step per dividend bit, load.
// A new sample enters only after the last average is loaded (divider: one quotient bit a cycle).
// The output register lets the next sample enter while the last average waits to be taken.
// Reset (rst, synchronous, active high): history reads as zero, sum and position cleared,
// window length returns to 16; no clearing pass, entry valid bits reset at once.
module running_average_window
  import rav_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // configuration: window length
  input  logic                     cfg_wr_en,
  input  logic [WIN_W-1:0]         cfg_wr_data,
  // sample input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] sample,
  // average output channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] average
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_UPDATE,
    S_DIV
  } state_t;

  state_t                   state;
  logic [WIN_W-1:0]         window_length;
  logic [POS_W-1:0]         write_position;
  logic signed [SUM_W-1:0]  running_sum;
  logic signed [DATA_W-1:0] held_sample;
  logic [MAX_TAPS-1:0]      history_valid;

  logic                     in_accept;
  logic                     out_take;
  logic                     out_load;
  logic [DATA_W-1:0]        ram_rdata;
  logic signed [DATA_W-1:0] old_sample;
  logic signed [SUM_W-1:0]  running_sum_next;
  logic [EWIN_W-1:0]        win_eff;
  logic [POS_W:0]           pos_inc;
  logic [POS_W-1:0]         write_position_next;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  // Accept a transaction only while idle and out of reset: one sample is in flight
  // at a time, so the history write of one sample always lands before the next
  // sample's read.
  assign in_stall  = rst || (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;
  // Load the output register once the quotient is ready and the register is free.
  assign out_load  = (state == S_DIV) && div_rsp.done && (!out_valid || !out_stall);

  // History ring: read at the write position, written back with the new sample.
  rav_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_TAPS)
  ) u_history (
    .clk   (clk),
    .we    (state == S_UPDATE),
    .waddr (write_position),
    .wdata (held_sample),
    .raddr (write_position),
    .rdata (ram_rdata)
  );

  // An entry never written since reset reads as zero.
  assign old_sample = history_valid[write_position] ? signed'(ram_rdata) : '0;

  // Add the new sample and drop the one being overwritten.
  assign running_sum_next = running_sum + SUM_W'(held_sample) - SUM_W'(old_sample);

  // Advance the position and wrap at the clamped window.
  assign win_eff             = eff_window(window_length);
  assign pos_inc             = {1'b0, write_position} + (POS_W + 1)'(1);
  assign write_position_next = (32'(pos_inc) >= 32'(win_eff)) ? '0 : pos_inc[POS_W-1:0];

  // Kick off the divide with the updated sum.
  assign div_req.start    = (state == S_UPDATE);
  assign div_req.dividend = running_sum_next;
  assign div_req.divisor  = win_eff;

  rav_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      window_length  <= WIN_RESET;
      write_position <= '0;
      running_sum    <= '0;
      history_valid  <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        window_length <= cfg_wr_data;
      end
      // A new average replaces the one taken in the same cycle.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            held_sample <= sample;
            state       <= S_READ;
          end
        end
        S_READ: begin
          // RAM read of the oldest entry is under way.
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          running_sum                   <= running_sum_next;
          history_valid[write_position] <= 1'b1;
          write_position                <= write_position_next;
          state                         <= S_DIV;
        end
        S_DIV: begin
          if (out_load) begin
            average <= signed'(div_rsp.quotient);
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // An accepted sample always moves on to the history read.
  assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == S_READ))
    else $error("accepted sample did not start a history read");

  // The running sum stays within the range of a full ring of samples.
  assert property (@(posedge clk) disable iff (rst)
    (32'(running_sum) >= -(MAX_TAPS * 32768)) && (32'(running_sum) <= MAX_TAPS * 32767))
    else $error("running sum out of range");

  // A new average appears only after the divider has finished.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(div_rsp.done))
    else $error("average loaded before divide completed");

  // The write position never leaves the ring.
  assert property (@(posedge clk) disable iff (rst)
    32'(write_position) < MAX_TAPS)
    else $error("write position outside history ring");
`endif

endmodule

// ===== test/tb_running_average_window.sv =====
// Testbench for running_average_window: predicts each window average and checks it.
`timescale 1ns / 100ps

// Predicts averages from accepted samples and checks results in order.
class average_checker;
  logic signed [rav_pkg::DATA_W-1:0] taps [rav_pkg::MAX_TAPS];
  int                                tap_sum;
  int unsigned                       next_slot;
  logic [rav_pkg::WIN_W-1:0]         window_reg;
  logic signed [rav_pkg::DATA_W-1:0] expected_averages [$];
  int                                mismatches;

  function new();
    foreach (taps[i]) taps[i] = '0;
    tap_sum    = 0;
    next_slot  = 0;
    window_reg = rav_pkg::WIN_RESET;
    mismatches = 0;
  endfunction

  function void set_window(logic [rav_pkg::WIN_W-1:0] value);
    window_reg = value;
  endfunction

  function int pending();
    return expected_averages.size();
  endfunction

  // Replace the oldest tap, update the sum and divide by the clamped window.
  function void note_sample(logic signed [rav_pkg::DATA_W-1:0] s);
    int span;
    int quotient;
    if (window_reg == 0) span = 1;
    else if (window_reg > rav_pkg::MAX_TAPS) span = rav_pkg::MAX_TAPS;
    else span = int'(window_reg);
    tap_sum = tap_sum + int'(s) - int'(taps[next_slot]);
    taps[next_slot] = s;
    next_slot = next_slot + 1;
    if (next_slot >= span) next_slot = 0;
    quotient = tap_sum / span;
    expected_averages.push_back(quotient[rav_pkg::DATA_W-1:0]);
  endfunction

  function void check_average(logic signed [rav_pkg::DATA_W-1:0] got);
    logic signed [rav_pkg::DATA_W-1:0] want;
    if (expected_averages.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("average %0d arrived with none expected", got);
    end else begin
      want = expected_averages.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("average mismatch: expected %0d, got %0d", want, got);
      end
    end
  endfunction
endclass

module tb_running_average_window;
  import rav_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  logic                     clk         = 1'b0;
  logic                     rst         = 1'b1;
  logic                     cfg_wr_en   = 1'b0;
  logic [WIN_W-1:0]         cfg_wr_data = '0;
  logic                     in_valid    = 1'b0;
  logic                     in_stall;
  logic signed [DATA_W-1:0] sample      = '0;
  logic                     out_valid;
  logic                     out_stall   = 1'b0;
  logic signed [DATA_W-1:0] average;

  average_checker sb;

  // Percent of cycles each side spends idle or stalled.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // Long output hold-off: set by the stimulus, counted down by the receiver.
  int hold_request   = 0;
  int hold_left      = 0;
  int cycles         = 0;

  running_average_window DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .average    (average)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Abort the run if it hangs; the limit is far above the slowest legal run.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: pick the stall for the next edge at the falling edge. A pending
  // hold request turns into a long run of stall cycles counted here.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Check every average transaction at the rising edge where it is taken.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_average(average);
  end

  function automatic void set_idling(idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 84; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 84; end
      default:   begin send_idle_pct = 14; recv_stall_pct = 14; end
    endcase
  endfunction

  // Mostly full-range noise, with a good share of extremes and tiny values.
  function automatic logic signed [DATA_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return DATA_W'($signed($urandom_range(15)) - 8);
      3:       return -16'sd1;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // Offer one sample, idling first at random, and hold it until taken.
  task automatic send_sample(input logic signed [DATA_W-1:0] s);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      sample   <= DATA_W'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sb.note_sample(s);
  endtask

  // Drop valid and hold off until every predicted average has been taken.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  // Write the window length; only called with the block idle.
  task automatic write_window(input logic [WIN_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    sb.set_window(value);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    sb = new();
    set_idling(IDLE_NONE);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset window of 16: extremes pile a large sum into the ring.
    repeat (6) send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(-16'sd1);
    send_sample(16'sd1);

    // Shrink the window to one while the position sits far beyond it: the
    // stale taps stay in the sum, so the quotient overflows and wraps.
    drain_results();
    write_window(5'd1);
    send_sample(16'sh7FFF);
    send_sample(16'sh5555);
    send_sample(16'shAAAA);

    // Zero window behaves as a window of one.
    drain_results();
    write_window(5'd0);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);

    // Oversized windows clamp to the full ring.
    drain_results();
    write_window(5'd31);
    send_sample(16'sh8000);
    send_sample(16'sh8000);
    send_sample(16'sh1234);
    drain_results();
    write_window(5'd17);
    send_sample(-16'sd7);
    send_sample(16'sh7FFF);

    // Random blocks, each with its own window and idling pattern.
    for (int blk = 0; blk < 8; blk++) begin
      drain_results();
      set_idling(idle_mode_e'(blk % 4));
      case (blk)
        0:       write_window(5'd5);
        1:       write_window(5'd16);
        2:       write_window(5'd1);
        3:       write_window(5'd0);
        4:       write_window(5'd31);
        5:       write_window(5'd17);
        6:       write_window(WIN_W'($urandom_range(2, 15)));
        default: write_window(WIN_W'($urandom_range(31)));
      endcase
      for (int n = 0; n < 150; n++) begin
        // Stall the output for a long stretch while samples keep coming, so
        // the block backs up and stalls its input.
        if (blk == 4 && n == 40) hold_request = 300;
        // Pause the sender until the pipeline is empty mid-block.
        if (blk == 5 && n == 75) drain_results();
        send_sample(pick_sample());
      end
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
